// ----- rtl/bpa_pkg.sv -----
// shared types and constants of the buddy page allocator
`default_nettype none

package bpa_pkg;

    // operation codes carried on the input tuser
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // configuration register index (byte address bit 2)
    localparam logic CFG_IDX_POOL_LOG2 = 1'b0;

    localparam logic [3:0] POOL_LOG2_RESET = 4'd10;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } bpa_status_t;

    // commands from controller to datapath, at most one action bit high
    typedef struct packed {
        logic        load;
        logic        clr_init;
        logic        clr_step;
        logic        size_step;
        logic        rd_root;
        logic        visit;
        logic        visit_child;
        logic        free_start;
        logic        climb_up;
        logic        restore;
        logic        asc_step;
        logic        push;
        bpa_status_t status;
    } bpa_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic op_free;
        logic size_fit;
        logic size_top;
        logic range_bad;
        logic root_short;
        logic vis_hit;
        logic vis_root;
        logic node_used;
        logic at_root;
        logic asc_last;
        logic clr_last;
        logic out_free;
    } bpa_flags_t;

endpackage

`default_nettype wire

// ----- rtl/bpa_ram.sv -----
// generic ram: one write port, one registered read port
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bpa_ctrl.sv -----
// controller state machine of the buddy page allocator
`default_nettype none

module bpa_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire bpa_pkg::bpa_flags_t flags,
    output bpa_pkg::bpa_cmd_t        cmd
);

    typedef enum logic [3:0] {
        S_CLR_INIT,
        S_CLR,
        S_IDLE,
        S_DISPATCH,
        S_SIZE,
        S_ROOT,
        S_DESC,
        S_CLIMB,
        S_ASC,
        S_FINISH
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    bpa_pkg::bpa_status_t status_reg;
    bpa_pkg::bpa_status_t status_next;
    logic                 pend_reg;

    assign in_ready = (state_reg == S_IDLE) && !pend_reg && !cfg_wr;

    always_comb
    begin
        cmd         = '0;
        cmd.status  = status_reg;
        state_next  = state_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_CLR_INIT:
            begin
                cmd.clr_init = 1'b1;
                state_next   = S_CLR;
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (flags.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (pend_reg || cfg_wr)
                begin
                    state_next = S_CLR_INIT;
                end
                else if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (!flags.op_free)
                begin
                    state_next = S_SIZE;
                end
                else if (flags.range_bad)
                begin
                    status_next = bpa_pkg::ST_RANGE;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.free_start = 1'b1;
                    state_next     = S_CLIMB;
                end
            end
            S_SIZE:
            begin
                priority if (flags.size_fit)
                begin
                    cmd.rd_root = 1'b1;
                    state_next  = S_ROOT;
                end
                else if (flags.size_top)
                begin
                    status_next = bpa_pkg::ST_NO_SPACE;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.size_step = 1'b1;
                end
            end
            S_ROOT, S_DESC:
            begin
                if (state_reg == S_ROOT && flags.root_short)
                begin
                    status_next = bpa_pkg::ST_NO_SPACE;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.visit       = 1'b1;
                    cmd.visit_child = (state_reg == S_DESC);
                    priority if (!flags.vis_hit)
                    begin
                        state_next = S_DESC;
                    end
                    else if (flags.vis_root)
                    begin
                        status_next = bpa_pkg::ST_OK;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_ASC;
                    end
                end
            end
            S_CLIMB:
            begin
                priority if (flags.node_used)
                begin
                    cmd.restore = 1'b1;
                    if (flags.at_root)
                    begin
                        status_next = bpa_pkg::ST_OK;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_ASC;
                    end
                end
                else if (flags.at_root)
                begin
                    status_next = bpa_pkg::ST_NOT_ALLOC;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.climb_up = 1'b1;
                end
            end
            S_ASC:
            begin
                cmd.asc_step = 1'b1;
                if (flags.asc_last)
                begin
                    status_next = bpa_pkg::ST_OK;
                    state_next  = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (flags.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLR_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR_INIT;
            status_reg <= bpa_pkg::ST_OK;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            // a pool write arriving mid-sweep forces another sweep
            if (cfg_wr)
            begin
                pend_reg <= 1'b1;
            end
            else if (state_reg == S_CLR_INIT)
            begin
                pend_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bpa_datapath.sv -----
// datapath of the buddy page allocator: tree memory, walk registers, result register
`default_nettype none

module bpa_datapath #(
    parameter int MAX_PAGES  = 1024,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bpa_pkg::bpa_cmd_t   cmd,
    output bpa_pkg::bpa_flags_t      flags,
    input  wire logic [3:0]          pool_log2,
    input  wire logic                in_op,
    input  wire logic [31:0]         in_bytes,
    input  wire logic [31:0]         in_off,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [9:0]               out_offset,
    output bpa_pkg::bpa_status_t     out_status
);

    // largest pool exponent that fits MAX_PAGES
    localparam int L     = $clog2(MAX_PAGES + 1) - 1;
    localparam int IDXW  = L + 1;
    localparam int IDXW1 = IDXW + 1;
    localparam int VW    = L + 1;
    localparam int VW1   = VW + 1;
    localparam int KW    = $clog2(L + 1);
    localparam int DEPTH = (2 << L) - 1;
    localparam int OFFW  = (L + 1 > 10) ? L + 1 : 11;
    localparam int SW    = 32 + L;
    localparam logic [SW-1:0] PB_W = SW'(PAGE_BYTES);

    logic              op_reg;
    logic [31:0]       bytes_reg;
    logic [31:0]       off_in_reg;
    logic [KW-1:0]     k_reg;
    logic [IDXW-1:0]   idx_reg;
    logic [KW-1:0]     nl_reg;
    logic [VW-1:0]     v_reg;
    logic [9:0]        res_off_reg;
    logic [VW-1:0]     clr_val_reg;
    logic [IDXW-1:0]   clr_end_reg;
    logic              out_valid_reg;
    logic [9:0]        out_offset_reg;
    bpa_pkg::bpa_status_t out_status_reg;

    logic              ram_we;
    logic [IDXW-1:0]   ram_waddr;
    logic [VW-1:0]     ram_wdata;
    logic              ram_re;
    logic [IDXW-1:0]   ram_raddr_a;
    logic [VW-1:0]     rd_a;

    function automatic logic [IDXW-1:0] parent_of(input logic [IDXW-1:0] i);
        parent_of = (i - IDXW'(1)) >> 1;
    endfunction

    function automatic logic [IDXW-1:0] sib_of(input logic [IDXW-1:0] i);
        sib_of = i[0] ? i + IDXW'(1) : i - IDXW'(1);
    endfunction

    logic [KW-1:0]     pl;
    logic [VW-1:0]     want;
    logic [IDXW-1:0]   pool_pages;
    logic [IDXW-1:0]   leaf;
    logic [IDXW-1:0]   child;
    logic [IDXW-1:0]   target;
    logic [KW-1:0]     tlog;
    logic [OFFW-1:0]   off_w;
    logic [KW-1:0]     nl_inc;
    logic [IDXW-1:0]   parent;
    logic [VW1-1:0]    psize;
    logic [VW1-1:0]    sum;
    logic [VW-1:0]     maxv;
    logic [VW-1:0]     pv;
    logic [IDXW1-1:0]  nodes_last;

    assign pl = ({28'b0, pool_log2} > 32'(L)) ? KW'(L) : KW'(pool_log2);
    assign want       = VW'(1) << k_reg;
    assign pool_pages = IDXW'(1) << pl;
    assign leaf       = IDXW'(off_in_reg) + pool_pages - IDXW'(1);

    // descent prefers the left child when it fits
    assign child  = (rd_a >= want) ? (idx_reg << 1) + IDXW'(1) : (idx_reg << 1) + IDXW'(2);
    assign target = cmd.visit_child ? child : idx_reg;
    assign tlog   = cmd.visit_child ? nl_reg - KW'(1) : nl_reg;
    assign off_w  = ((OFFW'(target) + OFFW'(1)) << k_reg) - (OFFW'(1) << pl);

    // parent value: merge when both halves are entirely free
    assign nl_inc = nl_reg + KW'(1);
    assign parent = parent_of(idx_reg);
    assign psize  = VW1'(1) << nl_inc;
    assign sum    = {1'b0, v_reg} + {1'b0, rd_a};
    assign maxv   = (v_reg > rd_a) ? v_reg : rd_a;
    assign pv     = (sum == psize) ? sum[VW-1:0] : maxv;

    assign nodes_last = (IDXW1'(1) << ({1'b0, pl} + 1'b1)) - IDXW1'(2);

    always_comb
    begin
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr_a = sib_of(idx_reg);
        priority if (cmd.clr_step)
        begin
            ram_we    = 1'b1;
            ram_wdata = clr_val_reg;
        end
        else if (cmd.rd_root)
        begin
            ram_re      = 1'b1;
            ram_raddr_a = '0;
        end
        else if (cmd.visit)
        begin
            ram_re = 1'b1;
            if (tlog == k_reg)
            begin
                ram_we      = 1'b1;
                ram_waddr   = target;
                ram_raddr_a = sib_of(target);
            end
            else
            begin
                ram_raddr_a = (target << 1) + IDXW'(1);
            end
        end
        else if (cmd.free_start)
        begin
            ram_re      = 1'b1;
            ram_raddr_a = leaf;
        end
        else if (cmd.climb_up)
        begin
            ram_re      = 1'b1;
            ram_raddr_a = parent;
        end
        else if (cmd.restore)
        begin
            ram_we    = 1'b1;
            ram_wdata = VW'(1) << nl_reg;
            ram_re    = 1'b1;
        end
        else if (cmd.asc_step)
        begin
            ram_we      = 1'b1;
            ram_waddr   = parent;
            ram_wdata   = pv;
            ram_re      = 1'b1;
            ram_raddr_a = sib_of(parent);
        end
        else
        begin
            ram_re = 1'b0;
        end
    end

    bpa_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_tree (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr_a),
        .rdata (rd_a)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_op;
            bytes_reg  <= in_bytes;
            off_in_reg <= in_off;
            k_reg      <= '0;
        end
        if (cmd.size_step)
        begin
            k_reg <= k_reg + KW'(1);
        end
        if (cmd.clr_init)
        begin
            idx_reg     <= '0;
            clr_val_reg <= VW'(1) << pl;
            clr_end_reg <= '0;
        end
        if (cmd.clr_step)
        begin
            idx_reg <= idx_reg + IDXW'(1);
            // last node of a level: sizes halve from the next one on
            if (idx_reg == clr_end_reg)
            begin
                clr_val_reg <= clr_val_reg >> 1;
                clr_end_reg <= (clr_end_reg << 1) + IDXW'(2);
            end
        end
        if (cmd.rd_root)
        begin
            idx_reg <= '0;
            nl_reg  <= pl;
        end
        if (cmd.visit)
        begin
            idx_reg     <= target;
            nl_reg      <= tlog;
            v_reg       <= '0;
            res_off_reg <= off_w[9:0];
        end
        if (cmd.free_start)
        begin
            idx_reg <= leaf;
            nl_reg  <= '0;
        end
        if (cmd.climb_up)
        begin
            idx_reg <= parent;
            nl_reg  <= nl_inc;
        end
        if (cmd.restore)
        begin
            v_reg <= VW'(1) << nl_reg;
        end
        if (cmd.asc_step)
        begin
            idx_reg <= parent;
            nl_reg  <= nl_inc;
            v_reg   <= pv;
        end
        if (cmd.push)
        begin
            out_status_reg <= cmd.status;
            out_offset_reg <= (cmd.status == bpa_pkg::ST_OK && op_reg == bpa_pkg::OP_ALLOC)
                              ? res_off_reg : 10'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        flags.op_free    = (op_reg == bpa_pkg::OP_FREE);
        flags.size_fit   = (PB_W << k_reg) >= SW'(bytes_reg);
        flags.size_top   = (k_reg == pl);
        flags.range_bad  = off_in_reg >= (32'd1 << pl);
        flags.root_short = rd_a < want;
        flags.vis_hit    = (tlog == k_reg);
        flags.vis_root   = (target == '0);
        flags.node_used  = (rd_a == '0);
        flags.at_root    = (idx_reg == '0);
        flags.asc_last   = (parent == '0);
        flags.clr_last   = ({1'b0, idx_reg} == nodes_last);
        flags.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_offset = out_offset_reg;
    assign out_status = out_status_reg;

endmodule

`default_nettype wire

// ----- rtl/buddy_page_allocator.sv -----
// top level of the buddy page allocator: config register, controller and datapath
//
//  channel   dir  handshake                 payload
//  s_        in   s_tvalid / s_tready       tdata: request_bytes, free_page_offset; tuser: operation
//  m_        out  m_tvalid / m_tready       tdata: page_offset; tuser: status
//  apb       in   psel penable pwrite       paddr, pwdata, prdata (pool_log2 at address 0)
//
// an allocate makes one size compare per cycle to find the rounded page count, then
// walks one tree level per cycle down and up, set by the registered read of the tree
// memory. a free climbs from the page's leaf to the nearest used node, then merges upward.
// after reset and after every pool_log2 write the tree is rebuilt by a sweep over
// all tree nodes, during which no transaction is taken on s_.
// a finished result waits in the output register; the next transaction is accepted meanwhile.
`default_nettype none

module buddy_page_allocator #(
    parameter int MAX_PAGES  = 1024,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] request_bytes, [63:32] free_page_offset
    input  wire logic [0:0]  s_tuser,   // [0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [9:0] page_offset, [15:10] zero
    output logic [1:0]       m_tuser,   // [1:0] status
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [3:0]           pool_log2_q_reg;
    logic                 cfg_wr;
    bpa_pkg::bpa_cmd_t    cmd;
    bpa_pkg::bpa_flags_t  flags;
    logic [9:0]           page_offset;
    bpa_pkg::bpa_status_t status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == bpa_pkg::CFG_IDX_POOL_LOG2);
    assign prdata = (paddr[2] == bpa_pkg::CFG_IDX_POOL_LOG2) ? {28'b0, pool_log2_q_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_log2_q_reg <= bpa_pkg::POOL_LOG2_RESET;
        end
        else if (cfg_wr)
        begin
            pool_log2_q_reg <= pwdata[3:0];
        end
    end

    bpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .flags    (flags),
        .cmd      (cmd)
    );

    bpa_datapath #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .flags      (flags),
        .pool_log2  (pool_log2_q_reg),
        .in_op      (s_tuser[0]),
        .in_bytes   (s_tdata[31:0]),
        .in_off     (s_tdata[63:32]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_offset (page_offset),
        .out_status (status)
    );

    assign m_tdata = {6'b0, page_offset};
    assign m_tuser = status;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// testbench of the buddy page allocator: queue-fed stream driver, tree predictor, result monitor
`timescale 1ns / 1ps

module tb;

    localparam int MAX_PAGES   = 1024;
    localparam int PAGE_BYTES  = 4096;
    localparam int TREE_NODES  = 2 * MAX_PAGES - 1;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 40;
    localparam int NUM_PHASES  = 12;
    localparam logic [2:0] POOL_LOG2_ADDR = {bpa_pkg::CFG_IDX_POOL_LOG2, 2'b00};

    typedef struct {
        logic        op;
        logic [31:0] nbytes;
        logic [31:0] page_off;
    } page_req_t;

    typedef struct {
        logic [9:0]           page;
        bpa_pkg::bpa_status_t status;
    } page_result_t;

    typedef struct {
        int unsigned first;
        int unsigned span;
    } live_block_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;     // [31:0] request_bytes, [63:32] free_page_offset
    logic [0:0]  s_tuser = '0;     // [0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [9:0] page_offset, [15:10] zero
    logic [1:0]  m_tuser;          // [1:0] status
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    buddy_page_allocator #(
        .MAX_PAGES (MAX_PAGES),
        .PAGE_BYTES(PAGE_BYTES)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 clk = ~clk;

    // predictor state: largest free block below each node
    logic [10:0]  free_tree [0:TREE_NODES-1];
    int unsigned  pool_pages;
    live_block_t  live_blocks[$];

    page_req_t    pending_reqs[$];
    page_result_t expected_results[$];
    page_req_t    cur_req;
    logic         gaps_on = 1'b1;

    int mismatches = 0;
    int accepted_reqs = 0;
    int checked_results = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int stall_cycles = 0;

    function automatic void pool_rebuild(input logic [3:0] lg);
        int unsigned n;
        int unsigned lvl;
        int unsigned i;
        n = 1;
        // oversized settings are capped at the largest pool that fits
        for (i = 0; i < lg && n * 2 <= MAX_PAGES; i++)
            n *= 2;
        pool_pages = n;
        lvl = n;
        for (i = 0; i < 2 * n - 1; i++)
        begin
            // first node of each level is a power of two minus one
            if (i != 0 && ((i + 1) & i) == 0)
                lvl /= 2;
            free_tree[i] = lvl[10:0];
        end
        live_blocks.delete();
    endfunction

    function automatic page_result_t pages_alloc(input logic [31:0] nbytes);
        page_result_t res;
        longint unsigned pages;
        int unsigned want;
        int unsigned idx;
        int unsigned span;
        int unsigned first;
        live_block_t blk;
        res.page = '0;
        res.status = bpa_pkg::ST_OK;
        pages = (longint'(nbytes) + PAGE_BYTES - 1) / PAGE_BYTES;
        if (pages == 0)
            pages = 1;
        if (pages > pool_pages)
        begin
            res.status = bpa_pkg::ST_NO_SPACE;
            return res;
        end
        want = 1;
        while (want < pages)
            want *= 2;
        if (free_tree[0] < want)
        begin
            res.status = bpa_pkg::ST_NO_SPACE;
            return res;
        end
        idx = 0;
        span = pool_pages;
        while (span != want)
        begin
            idx = (free_tree[2 * idx + 1] >= want) ? 2 * idx + 1 : 2 * idx + 2;
            span /= 2;
        end
        free_tree[idx] = '0;
        first = (idx + 1) * span - pool_pages;
        while (idx != 0)
        begin
            idx = (idx - 1) / 2;
            free_tree[idx] = (free_tree[2 * idx + 1] > free_tree[2 * idx + 2]) ?
                             free_tree[2 * idx + 1] : free_tree[2 * idx + 2];
        end
        res.page = first[9:0];
        blk.first = first;
        blk.span = span;
        live_blocks.push_back(blk);
        return res;
    endfunction

    function automatic page_result_t pages_release(input logic [31:0] off);
        page_result_t res;
        int unsigned idx;
        int unsigned span;
        int unsigned l;
        int unsigned r;
        res.page = '0;
        res.status = bpa_pkg::ST_OK;
        if (off >= pool_pages)
        begin
            res.status = bpa_pkg::ST_RANGE;
            return res;
        end
        idx = off + pool_pages - 1;
        span = 1;
        // climb to the nearest used node above the page
        while (free_tree[idx] != 0)
        begin
            if (idx == 0)
            begin
                res.status = bpa_pkg::ST_NOT_ALLOC;
                return res;
            end
            span *= 2;
            idx = (idx - 1) / 2;
        end
        free_tree[idx] = span[10:0];
        while (idx != 0)
        begin
            idx = (idx - 1) / 2;
            span *= 2;
            l = free_tree[2 * idx + 1];
            r = free_tree[2 * idx + 2];
            // buddies both whole again merge into one block
            if (l + r == span)
                free_tree[idx] = span[10:0];
            else
                free_tree[idx] = (l > r) ? l[10:0] : r[10:0];
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task automatic push_req(input logic op, input logic [31:0] nbytes, input logic [31:0] off);
        page_req_t req;
        req.op = op;
        req.nbytes = nbytes;
        req.page_off = off;
        pending_reqs.push_back(req);
    endtask

    // sampled at the falling edge so every update of the rising edge has landed
    task automatic wait_drained();
        @(negedge clk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_pool_log2(input logic [3:0] lg);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= POOL_LOG2_ADDR;
        pwdata <= {28'd0, lg};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        pool_rebuild(lg);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        page_result_t res;
        page_req_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (cur_req.op == bpa_pkg::OP_ALLOC)
                    res = pages_alloc(cur_req.nbytes);
                else
                    res = pages_release(cur_req.page_off);
                expected_results.push_back(res);
                accepted_reqs++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_reqs.size() != 0 && !(gaps_on && $urandom_range(99) < 26))
                begin
                    nxt = pending_reqs.pop_front();
                    cur_req <= nxt;
                    s_tvalid <= 1'b1;
                    s_tdata <= {nxt.page_off, nxt.nbytes};
                    s_tuser <= nxt.op;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        page_result_t exp_res;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected result page %0d status %0d",
                                            m_tdata[9:0], m_tuser));
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    checked_results++;
                    status_seen[exp_res.status]++;
                    if (m_tdata[9:0] != exp_res.page)
                        flag_mismatch($sformatf("result %0d page_offset %0d, want %0d",
                                                checked_results, m_tdata[9:0], exp_res.page));
                    if (m_tuser != exp_res.status)
                        flag_mismatch($sformatf("result %0d status %0d, want %0d",
                                                checked_results, m_tuser, exp_res.status));
                end
            end
            m_tready <= !(gaps_on && $urandom_range(99) < 26);
        end
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pwrite))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("tb failed");
                $finish;
            end
        end
    end

    initial
    begin
        int pool_settings[NUM_PHASES];
        int phase_items[NUM_PHASES];
        int ph;
        int n;
        int r;
        int pg;
        int psize;
        int pick;
        live_block_t blk;
        logic [31:0] nbytes;
        logic [31:0] off;

        pool_settings = '{10, 0, 15, 3, 1, 5, 12, 2, 10, 4, 11, 7};
        phase_items   = '{300, 60, 250, 150, 80, 150, 200, 80, 300, 120, 150, 100};
        pool_rebuild(bpa_pkg::POOL_LOG2_RESET);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // tree clearing sweep after reset holds s_tready low
        while (!s_tready)
            @(posedge clk);

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge clk);
            write_pool_log2(pool_settings[ph][3:0]);
            // one full phase with no gaps on either side
            gaps_on <= (ph != 8);

            if (ph == 0)
            begin
                push_req(bpa_pkg::OP_ALLOC, 32'd0, $urandom);
                push_req(bpa_pkg::OP_ALLOC, 32'd1, $urandom);
                push_req(bpa_pkg::OP_ALLOC, PAGE_BYTES, $urandom);
                push_req(bpa_pkg::OP_ALLOC, PAGE_BYTES + 1, $urandom);
                push_req(bpa_pkg::OP_ALLOC, 3 * PAGE_BYTES, $urandom);
                push_req(bpa_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                push_req(bpa_pkg::OP_ALLOC, MAX_PAGES * PAGE_BYTES + 1, 32'd0);
                push_req(bpa_pkg::OP_FREE, $urandom, 32'hFFFF_FFFF);
                push_req(bpa_pkg::OP_FREE, 32'hFFFF_FFFF, MAX_PAGES);
                push_req(bpa_pkg::OP_FREE, 32'd0, MAX_PAGES - 1);
                // page inside a used block releases the whole block
                push_req(bpa_pkg::OP_FREE, $urandom, 32'd9);
                push_req(bpa_pkg::OP_FREE, $urandom, 32'd8);
                push_req(bpa_pkg::OP_FREE, $urandom, 32'd0);
                push_req(bpa_pkg::OP_FREE, $urandom, 32'd1);
                push_req(bpa_pkg::OP_FREE, $urandom, 32'd2);
                push_req(bpa_pkg::OP_FREE, $urandom, 32'd4);
                push_req(bpa_pkg::OP_ALLOC, MAX_PAGES * PAGE_BYTES, $urandom);
                push_req(bpa_pkg::OP_ALLOC, 32'd0, $urandom);
                push_req(bpa_pkg::OP_FREE, $urandom, 32'd512);
                push_req(bpa_pkg::OP_FREE, $urandom, 32'd0);
                push_req(bpa_pkg::OP_ALLOC, 512 * PAGE_BYTES, $urandom);
                push_req(bpa_pkg::OP_ALLOC, 512 * PAGE_BYTES, $urandom);
                push_req(bpa_pkg::OP_ALLOC, 32'd1, $urandom);
                push_req(bpa_pkg::OP_FREE, $urandom, 32'd1023);
                push_req(bpa_pkg::OP_FREE, $urandom, 32'd0);
                wait_drained();
            end

            for (n = 0; n < phase_items[ph]; n++)
            begin
                // keep the queue short so frees see recent allocations
                while (pending_reqs.size() >= 4)
                    @(posedge clk);
                psize = pool_pages;
                r = $urandom_range(99);
                if (live_blocks.size() != 0 && r < 40)
                begin
                    pick = $urandom_range(live_blocks.size() - 1);
                    blk = live_blocks[pick];
                    live_blocks.delete(pick);
                    off = blk.first;
                    if ($urandom_range(99) < 20)
                        off = blk.first + $urandom_range(blk.span - 1);
                    push_req(bpa_pkg::OP_FREE, $urandom, off);
                end
                else if (r < 46)
                begin
                    if ($urandom_range(1))
                        off = $urandom;
                    else
                        off = $urandom_range(psize - 1);
                    push_req(bpa_pkg::OP_FREE, $urandom, off);
                end
                else
                begin
                    r = $urandom_range(99);
                    if (r < 5)
                    begin
                        nbytes = 32'd0;
                    end
                    else if (r < 10)
                    begin
                        nbytes = $urandom;
                    end
                    else
                    begin
                        if (r < 70)
                            pg = $urandom_range(1, (psize < 4) ? psize : 4);
                        else if (r < 95)
                            pg = $urandom_range(1, psize);
                        else
                            pg = psize + $urandom_range(1, psize);
                        nbytes = (pg - 1) * PAGE_BYTES + $urandom_range(1, PAGE_BYTES);
                    end
                    push_req(bpa_pkg::OP_ALLOC, nbytes, $urandom);
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        $display("%0d requests over %0d pool sizes, %0d results checked",
                 accepted_reqs, NUM_PHASES, checked_results);
        $display("status mix: ok %0d, no space %0d, out of range %0d, not allocated %0d",
                 status_seen[bpa_pkg::ST_OK], status_seen[bpa_pkg::ST_NO_SPACE],
                 status_seen[bpa_pkg::ST_RANGE], status_seen[bpa_pkg::ST_NOT_ALLOC]);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
